// ===== hw/rtl/fpsf_pkg.sv =====
// Shared types, widths and kernel coefficients of the five-point smoothing filter.
`timescale 1ns / 1ps

package fpsf_pkg;

   localparam int SAMPLE_BITS = 16;
   // Largest kernel weight sum is 51, so six bits of growth cover every sum.
   localparam int NUM_BITS    = SAMPLE_BITS + 6;
   localparam int COEF_BITS   = 6;
   localparam int TAPS        = 4;
   localparam int KERNELS     = 5;
   localparam int SLOTS       = 5;
   localparam int COUNT_BITS  = 3;

   localparam logic [COUNT_BITS-1:0] CNT_HEAD = COUNT_BITS'(4);
   localparam logic [COUNT_BITS-1:0] CNT_FULL = COUNT_BITS'(5);

   // Kernel indexes, in the order their results leave the block.
   localparam int K_HEAD0 = 0;
   localparam int K_HEAD1 = 1;
   localparam int K_MID   = 2;
   localparam int K_TAIL1 = 3;
   localparam int K_TAIL0 = 4;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [NUM_BITS-1:0]    num_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef coef_type [KERNELS-1:0]        coef_row_type;
   typedef num_type  [KERNELS-1:0]        psum_type;

   // Weights over the window, oldest sample first, scaled by 35.
   localparam coef_type KERNEL_COEF [KERNELS][TAPS+1] = '{
      '{ 6'sd31,  6'sd9,  -6'sd3, -6'sd5,  6'sd3  },
      '{ 6'sd9,   6'sd13,  6'sd12, 6'sd6, -6'sd5  },
      '{-6'sd3,   6'sd12,  6'sd17, 6'sd12,-6'sd3  },
      '{-6'sd5,   6'sd6,   6'sd12, 6'sd13, 6'sd9  },
      '{ 6'sd3,  -6'sd5,  -6'sd3,  6'sd9,  6'sd31 }
   };

   typedef struct packed {
      logic    valid;
      num_type num;
      logic    eor;
      logic    status;
   } slot_type;

   typedef struct packed {
      sample_type smoothed;
      logic       eor;
      logic       status;
   } result_type;

endpackage

// ===== hw/rtl/fpsf_tap_cell.sv =====
// One window tap: holds a sample and adds its weighted share to every kernel sum.
`timescale 1ns / 1ps

module fpsf_tap_cell (
   input  logic                  clock,
   input  logic                  shift,
   input  fpsf_pkg::sample_type  sample_in,
   input  fpsf_pkg::coef_row_type coef,
   input  fpsf_pkg::psum_type    psum_in,
   output fpsf_pkg::sample_type  sample_out,
   output fpsf_pkg::psum_type    psum_out
);

   fpsf_pkg::sample_type tap_ff;
   fpsf_pkg::sample_type tap_in;

   assign tap_in = shift ? sample_in : tap_ff;

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   assign sample_out = tap_ff;

   always_comb begin
      for (int k = 0; k < fpsf_pkg::KERNELS; k++) begin
         psum_out[k] = fpsf_pkg::num_type'($signed(psum_in[k]))
                     + fpsf_pkg::num_type'($signed(coef[k]))
                     * fpsf_pkg::num_type'(tap_ff);
      end
   end

endmodule

// ===== hw/rtl/fpsf_slot_cell.sv =====
// One result slot of the drain chain: loads a fresh result or takes its neighbour's.
`timescale 1ns / 1ps

module fpsf_slot_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                shift,
   input  fpsf_pkg::slot_type  load_entry,
   input  fpsf_pkg::slot_type  next_entry,
   output fpsf_pkg::slot_type  entry
);

   fpsf_pkg::slot_type entry_ff;
   fpsf_pkg::slot_type entry_in;
   logic               valid_ff;
   logic               valid_in;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (load) begin
         entry_in = load_entry;
         valid_in = load_entry.valid;
      end else if (shift) begin
         entry_in = next_entry;
         valid_in = next_entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_comb begin
      entry       = entry_ff;
      entry.valid = valid_ff;
   end

endmodule

// ===== hw/rtl/fpsf_div35.sv =====
// Rounded divide by 35 with saturation, two pipeline stages ending in the output register.
`timescale 1ns / 1ps

module fpsf_div35 (
   input  logic                 clock,
   input  logic                 reset,
   input  fpsf_pkg::slot_type   in_entry,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output fpsf_pkg::result_type out_result
);

   localparam int MAG_BITS   = fpsf_pkg::NUM_BITS;
   localparam int RSHIFT     = MAG_BITS;
   localparam int RECIP_BITS = RSHIFT - 5;
   localparam int PROD_BITS  = MAG_BITS + RECIP_BITS;
   localparam int SB         = fpsf_pkg::SAMPLE_BITS;
   localparam logic [63:0] RECIP_FULL = (64'd1 << RSHIFT) / 64'd35;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];
   localparam logic [MAG_BITS-1:0] DIVISOR = MAG_BITS'(35);
   localparam logic [MAG_BITS-1:0] HALF    = MAG_BITS'(17);
   localparam logic [MAG_BITS-1:0] POS_MAX = MAG_BITS'((64'd1 << (SB - 1)) - 64'd1);
   localparam logic [MAG_BITS-1:0] NEG_MAX = MAG_BITS'(64'd1 << (SB - 1));
   localparam logic [SB-1:0] SAT_HI = {1'b0, {(SB - 1){1'b1}}};
   localparam logic [SB-1:0] SAT_LO = {1'b1, {(SB - 1){1'b0}}};

   // stage one: magnitude plus half divisor, reciprocal estimate
   logic                 s1_valid_ff, s1_valid_in;
   logic [MAG_BITS-1:0]  m_ff, m_in;
   logic [MAG_BITS-1:0]  q_est_ff, q_est_in;
   logic                 neg_ff, neg_in;
   logic                 s1_eor_ff, s1_status_ff;
   logic                 s1_ready;

   logic [MAG_BITS-1:0]  mag;
   logic [PROD_BITS-1:0] product;

   // stage two: output register
   logic                 out_valid_ff, out_valid_in;
   fpsf_pkg::result_type out_ff, out_in;
   logic                 s2_ready;

   logic [MAG_BITS-1:0]  rem;
   logic [MAG_BITS-1:0]  q_fix;

   assign s2_ready = !out_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      neg_in   = in_entry.num[fpsf_pkg::NUM_BITS-1];
      mag      = neg_in ? MAG_BITS'(-in_entry.num) : MAG_BITS'(in_entry.num);
      m_in     = mag + HALF;
      product  = PROD_BITS'(m_in) * PROD_BITS'(RECIP);
      q_est_in = MAG_BITS'(product[PROD_BITS-1:RSHIFT]);
      s1_valid_in = s1_ready ? in_entry.valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_entry.valid) begin
         m_ff         <= m_in;
         q_est_ff     <= q_est_in;
         neg_ff       <= neg_in;
         s1_eor_ff    <= in_entry.eor;
         s1_status_ff <= in_entry.status;
      end
   end

   // the estimate is low by at most one; one compare fixes it
   always_comb begin
      rem   = m_ff - MAG_BITS'(q_est_ff * DIVISOR);
      q_fix = (rem >= DIVISOR) ? q_est_ff + MAG_BITS'(1) : q_est_ff;
      out_in.eor    = s1_eor_ff;
      out_in.status = s1_status_ff;
      if (neg_ff) begin
         out_in.smoothed = (q_fix > NEG_MAX) ? SAT_LO : SB'(-q_fix);
      end else begin
         out_in.smoothed = (q_fix > POS_MAX) ? SAT_HI : SB'(q_fix);
      end
      out_valid_in = s2_ready ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

// ===== hw/rtl/five_point_smoothing_filter.sv =====
// Top level of the streaming five-point quadratic smoothing filter.
`timescale 1ns / 1ps

// Five-point quadratic smoother over a stream of signed samples, a sequence closed by
// req_last. A sample that releases at most one result is taken every cycle unless the
// result side holds off. The fifth sample of a sequence releases three results and a
// closing sample three or five; all results drain one per cycle from a five-slot result
// chain while rsp_ready is high, and req_ready stays low until the chain holds one
// result. The first result of a sample passes the slot chain and the two-stage divide
// by 35 before it reaches rsp_valid, the others behind it. A sequence shorter than
// five samples gives one result with rsp_status high, rsp_smoothed zero and
// rsp_end_of_run high. Values are rounded to nearest and saturated to the sample range.

module five_point_smoothing_filter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [fpsf_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [fpsf_pkg::SAMPLE_BITS-1:0] rsp_smoothed,
   output logic                      rsp_end_of_run,
   output logic                      rsp_status
);

   localparam int TAPS    = fpsf_pkg::TAPS;
   localparam int KERNELS = fpsf_pkg::KERNELS;
   localparam int SLOTS   = fpsf_pkg::SLOTS;

   logic                               req_accept;
   logic [fpsf_pkg::COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                               cnt_short, cnt_head;

   fpsf_pkg::sample_type   tap_q   [TAPS];
   fpsf_pkg::sample_type   tap_d   [TAPS];
   fpsf_pkg::coef_row_type tap_coef [TAPS];
   fpsf_pkg::psum_type     psum_chain [TAPS+1];
   fpsf_pkg::num_type      kern_sum [KERNELS];

   fpsf_pkg::slot_type     slot_new [SLOTS];
   fpsf_pkg::slot_type     slot_q   [SLOTS+1];
   logic [SLOTS-1:0]       slot_valid;
   logic                   div_ready;
   logic                   pop;
   fpsf_pkg::result_type   result;

   assign req_accept = req_valid && req_ready;
   assign pop        = slot_q[0].valid && div_ready;
   // take a sample only once the chain will hold nothing after this cycle's pop
   assign req_ready  = !slot_q[1].valid && (!slot_q[0].valid || div_ready);

   // window taps, oldest at index zero
   always_comb begin
      for (int p = 0; p < TAPS; p++) begin
         for (int k = 0; k < KERNELS; k++) begin
            tap_coef[p][k] = fpsf_pkg::KERNEL_COEF[k][p];
         end
         tap_d[p] = (p == TAPS - 1) ? req_sample : tap_q[(p + 1) % TAPS];
      end
   end

   assign psum_chain[0] = '0;

   for (genvar p = 0; p < TAPS; p++) begin : g_tap
      fpsf_tap_cell u_tap (
         .clock      (clock),
         .shift      (req_accept),
         .sample_in  (tap_d[p]),
         .coef       (tap_coef[p]),
         .psum_in    (psum_chain[p]),
         .sample_out (tap_q[p]),
         .psum_out   (psum_chain[p+1])
      );
   end

   always_comb begin
      for (int k = 0; k < KERNELS; k++) begin
         kern_sum[k] = fpsf_pkg::num_type'($signed(psum_chain[TAPS][k]))
                     + fpsf_pkg::num_type'(fpsf_pkg::KERNEL_COEF[k][TAPS])
                     * fpsf_pkg::num_type'(req_sample);
      end
   end

   assign cnt_short = cnt_ff < fpsf_pkg::CNT_HEAD;
   assign cnt_head  = cnt_ff == fpsf_pkg::CNT_HEAD;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_accept) begin
         if (req_last) begin
            cnt_in = '0;
         end else if (cnt_short) begin
            cnt_in = cnt_ff + fpsf_pkg::COUNT_BITS'(1);
         end else begin
            cnt_in = fpsf_pkg::CNT_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // results released by the sample on offer, in delivery order
   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_new[s] = '0;
      end
      if (cnt_short) begin
         if (req_last) begin
            slot_new[0] = '{valid: 1'b1, num: '0, eor: 1'b1, status: 1'b1};
         end
      end else if (cnt_head) begin
         slot_new[0] = '{1'b1, kern_sum[fpsf_pkg::K_HEAD0], 1'b0, 1'b0};
         slot_new[1] = '{1'b1, kern_sum[fpsf_pkg::K_HEAD1], 1'b0, 1'b0};
         slot_new[2] = '{1'b1, kern_sum[fpsf_pkg::K_MID], 1'b0, 1'b0};
         slot_new[3] = '{req_last, kern_sum[fpsf_pkg::K_TAIL1], 1'b0, 1'b0};
         slot_new[4] = '{req_last, kern_sum[fpsf_pkg::K_TAIL0], 1'b1, 1'b0};
      end else begin
         slot_new[0] = '{1'b1, kern_sum[fpsf_pkg::K_MID], 1'b0, 1'b0};
         slot_new[1] = '{req_last, kern_sum[fpsf_pkg::K_TAIL1], 1'b0, 1'b0};
         slot_new[2] = '{req_last, kern_sum[fpsf_pkg::K_TAIL0], 1'b1, 1'b0};
      end
   end

   assign slot_q[SLOTS] = '0;

   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      fpsf_slot_cell u_slot (
         .clock      (clock),
         .reset      (reset),
         .load       (req_accept),
         .shift      (pop),
         .load_entry (slot_new[s]),
         .next_entry (slot_q[s+1]),
         .entry      (slot_q[s])
      );
      assign slot_valid[s] = slot_q[s].valid;
   end

   fpsf_div35 u_div (
      .clock      (clock),
      .reset      (reset),
      .in_entry   (slot_q[0]),
      .in_ready   (div_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_smoothed   = result.smoothed;
   assign rsp_end_of_run = result.eor;
   assign rsp_status     = result.status;

   // slots fill from the head with no gaps
   a_slots_packed : assert property (@(posedge clock) disable iff (reset)
      ((slot_valid + SLOTS'(1)) & slot_valid) == '0)
      else $error("result chain holds a gap");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= fpsf_pkg::CNT_FULL)
      else $error("sample count out of range");

   a_count_clear : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last |=> cnt_ff == '0)
      else $error("sample count not cleared after closing transaction");

   a_fill_silent : assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_last && cnt_short |=> !slot_valid[0])
      else $error("window fill released a result");

   a_short_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_end_of_run && rsp_smoothed == '0)
      else $error("short sequence result malformed");

endmodule

// ===== sim/five_point_smoothing_filter_tb.sv =====
// Self-checking testbench of the five-point smoothing filter, results predicted in order.
`timescale 1ns / 1ps

module five_point_smoothing_filter_tb;

   localparam int     HOLD_CYCLES   = 60;
   localparam int     SETTLE_CYCLES = 10;
   localparam longint SAT_HI        = (longint'(1) <<< (fpsf_pkg::SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO        = -SAT_HI - 1;
   localparam fpsf_pkg::sample_type S_MAX = {1'b0, {(fpsf_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam fpsf_pkg::sample_type S_MIN = {1'b1, {(fpsf_pkg::SAMPLE_BITS-1){1'b0}}};

   // Savitzky-Golay weights, scaled by 35, rows in kernel index order.
   localparam int SG_WEIGHTS [fpsf_pkg::KERNELS][fpsf_pkg::TAPS+1] = '{
      '{ 31,  9, -3, -5,  3},
      '{  9, 13, 12,  6, -5},
      '{ -3, 12, 17, 12, -3},
      '{ -5,  6, 12, 13,  9},
      '{  3, -5, -3,  9, 31}
   };

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   fpsf_pkg::sample_type req_sample     = '0;
   logic                 req_last       = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   fpsf_pkg::sample_type rsp_smoothed;
   logic                 rsp_end_of_run;
   logic                 rsp_status;

   // Predictor state: the four latest samples, oldest first, and the sample count.
   fpsf_pkg::sample_type            hist [fpsf_pkg::TAPS];
   logic [fpsf_pkg::COUNT_BITS-1:0] seen = '0;
   fpsf_pkg::result_type            expected_q [$];

   int mismatch_count = 0;
   bit idle_on        = 1'b1;
   int holds_wanted   = 0;
   int holds_granted  = 0;
   int hold_left      = 0;

   five_point_smoothing_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_smoothed   (rsp_smoothed),
      .rsp_end_of_run (rsp_end_of_run),
      .rsp_status     (rsp_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic fpsf_pkg::sample_type smooth_tap(int k,
         fpsf_pkg::sample_type taps [fpsf_pkg::TAPS+1]);
      longint acc;
      longint q;
      acc = 0;
      for (int i = 0; i <= fpsf_pkg::TAPS; i++)
         acc += longint'(SG_WEIGHTS[k][i]) * longint'(taps[i]);
      // Round half away from zero; 35 is odd so no true tie exists.
      if (acc >= 0)
         q = (acc + 17) / 35;
      else
         q = -((-acc + 17) / 35);
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      return fpsf_pkg::sample_type'(q);
   endfunction

   task automatic expect_result(fpsf_pkg::sample_type v, logic eor, logic st);
      fpsf_pkg::result_type r;
      r.smoothed = v;
      r.eor      = eor;
      r.status   = st;
      expected_q.push_back(r);
   endtask

   task automatic predict_sample(fpsf_pkg::sample_type x, logic fin);
      fpsf_pkg::sample_type taps [fpsf_pkg::TAPS+1];
      if (seen < fpsf_pkg::CNT_HEAD) begin
         hist[seen[1:0]] = x;
         seen = seen + 1'b1;
         // Sequence closed before the window filled: one error result.
         if (fin) begin
            expect_result('0, 1'b1, 1'b1);
            seen = '0;
         end
      end else begin
         for (int i = 0; i < fpsf_pkg::TAPS; i++)
            taps[i] = hist[i];
         taps[fpsf_pkg::TAPS] = x;
         if (seen == fpsf_pkg::CNT_HEAD) begin
            expect_result(smooth_tap(fpsf_pkg::K_HEAD0, taps), 1'b0, 1'b0);
            expect_result(smooth_tap(fpsf_pkg::K_HEAD1, taps), 1'b0, 1'b0);
         end
         expect_result(smooth_tap(fpsf_pkg::K_MID, taps), 1'b0, 1'b0);
         if (fin) begin
            expect_result(smooth_tap(fpsf_pkg::K_TAIL1, taps), 1'b0, 1'b0);
            expect_result(smooth_tap(fpsf_pkg::K_TAIL0, taps), 1'b1, 1'b0);
         end
         for (int i = 0; i < fpsf_pkg::TAPS; i++)
            hist[i] = taps[i+1];
         seen = fin ? '0 : fpsf_pkg::CNT_FULL;
      end
   endtask

   // Called just after a falling edge; returns at the falling edge after acceptance.
   task automatic send_sample(fpsf_pkg::sample_type s, logic fin);
      if (idle_on)
         while ($urandom_range(0, 99) < 29) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= fin;
      do
         @(posedge clock);
      while (!req_ready);
      predict_sample(s, fin);
      @(negedge clock);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic fpsf_pkg::sample_type pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         case ($urandom_range(0, 3))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            default: return '1;
         endcase
      end else if (r < 50) begin
         return fpsf_pkg::sample_type'(int'($urandom_range(0, 200)) - 100);
      end
      return fpsf_pkg::sample_type'($urandom);
   endfunction

   // Send whole sequences, mostly long enough to fill the window, until n samples have gone.
   task automatic send_random_runs(int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 15)
            len = $urandom_range(1, 4);
         else
            len = $urandom_range(5, 16);
         if (len > n_items - sent)
            len = n_items - sent;
         for (int i = 0; i < len; i++)
            send_sample(pick_sample(), i == len - 1);
         sent += len;
      end
   endtask

   task automatic test_short_sequences;
      fpsf_pkg::sample_type edge_vals [4];
      edge_vals = '{S_MAX, S_MIN, '0, '1};
      for (int len = 1; len <= 4; len++)
         for (int i = 0; i < len; i++)
            send_sample(edge_vals[(len + i) % 4], i == len - 1);
      drain_results();
   endtask

   // Five-sample sequences release all five results at once; patterns drive the first head
   // kernel into both saturation limits and the middle kernel into the upper one.
   task automatic test_five_sample_saturation;
      fpsf_pkg::sample_type pattern [15];
      pattern = '{S_MAX, S_MAX, S_MIN, S_MIN, S_MAX,
                  S_MIN, S_MIN, S_MAX, S_MAX, S_MIN,
                  S_MIN, S_MAX, S_MAX, S_MAX, S_MIN};
      for (int i = 0; i < 15; i++)
         send_sample(pattern[i], (i % 5) == 4);
      drain_results();
   endtask

   task automatic test_random_sequences;
      idle_on = 1'b1;
      send_random_runs(55);
      drain_results();
   endtask

   task automatic test_back_to_back;
      idle_on = 1'b0;
      send_random_runs(30);
      drain_results();
      idle_on = 1'b1;
   endtask

   // Hold the result side off while samples keep coming, so the input stalls.
   task automatic test_output_hold;
      idle_on = 1'b0;
      holds_wanted++;
      send_random_runs(25);
      drain_results();
      idle_on = 1'b1;
   endtask

   always @(negedge clock) begin
      if (holds_granted != holds_wanted) begin
         holds_granted = holds_wanted;
         hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 29) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      fpsf_pkg::result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result: smoothed %0d end_of_run %0b status %0b",
                   rsp_smoothed, rsp_end_of_run, rsp_status);
            mismatch_count++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_smoothed !== exp_r.smoothed) begin
               $error("smoothed: expected %0d, actual %0d", exp_r.smoothed, rsp_smoothed);
               mismatch_count++;
            end
            if (rsp_end_of_run !== exp_r.eor) begin
               $error("end_of_run: expected %0b, actual %0b", exp_r.eor, rsp_end_of_run);
               mismatch_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0b, actual %0b", exp_r.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_short_sequences();
      test_five_sample_saturation();
      test_random_sequences();
      test_back_to_back();
      test_output_hold();
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
